// ===== hw/rtl/bts_pkg.sv =====
// Shared constants, types and a helper function of the byte taint shadow map.
package bts_pkg;

  localparam int ADDR_BITS     = 16;
  localparam int MARK_W        = 64;
  localparam int OFF_BITS      = 6;
  localparam int COUNT_W       = 7;
  localparam int WORD_IDX_BITS = ADDR_BITS - OFF_BITS;
  localparam int BANK_IDX_BITS = WORD_IDX_BITS - 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = 1;
  localparam int QCNT_BITS     = 2;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MARK_W);

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  typedef struct packed {
    logic                     func;
    logic                     swap;
    logic [BANK_IDX_BITS-1:0] addr_even;
    logic [BANK_IDX_BITS-1:0] addr_odd;
    logic [OFF_BITS-1:0]      off;
    logic [COUNT_W-1:0]       len0;
    logic [MARK_W-1:0]        mask_lo;
    logic [MARK_W-1:0]        mask_hi;
    logic [MARK_W-1:0]        wmask_lo;
    logic [MARK_W-1:0]        data_lo;
    logic [MARK_W-1:0]        data_hi;
  } bts_cmd_t;

  function automatic logic [MARK_W-1:0] low_ones(input logic [COUNT_W-1:0] n);
    logic [MARK_W-1:0] res;
    if (n >= FULL_COUNT) begin
      res = '1;
    end else begin
      res = (MARK_W'(1) << n) - MARK_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/bts_front.sv =====
// Front end: accepts words and turns them into per-bank commands with masks.
module bts_front import bts_pkg::*; (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [15:0]          in_byte_address,
  input  logic [COUNT_W-1:0]   in_byte_count,
  input  logic [MARK_W-1:0]    in_mark_pattern,
  input  logic                 q_full,
  input  logic                 clear_done,
  output logic                 q_push,
  output bts_cmd_t             q_cmd
);

  logic [ADDR_BITS-1:0]     addr;
  logic [COUNT_W-1:0]       count;
  logic [OFF_BITS-1:0]      off;
  logic [COUNT_W-1:0]       room;
  logic [COUNT_W-1:0]       len0;
  logic [COUNT_W-1:0]       len1;
  logic [MARK_W-1:0]        m0;
  logic [MARK_W-1:0]        m1;
  logic [WORD_IDX_BITS-1:0] w0;
  logic [WORD_IDX_BITS-1:0] w1;

  assign in_ready = clear_done && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    addr  = in_byte_address[ADDR_BITS-1:0];
    count = (in_byte_count > FULL_COUNT) ? FULL_COUNT : in_byte_count;
    off   = addr[OFF_BITS-1:0];
    room  = FULL_COUNT - COUNT_W'(off);
    len0  = (room > count) ? count : room;
    len1  = count - len0;
    m0    = low_ones(len0);
    m1    = low_ones(len1);
    w0    = addr[ADDR_BITS-1:OFF_BITS];
    w1    = w0 + WORD_IDX_BITS'(1);

    q_cmd.func      = in_func;
    q_cmd.swap      = w0[0];
    q_cmd.addr_even = w0[0] ? w1[WORD_IDX_BITS-1:1] : w0[WORD_IDX_BITS-1:1];
    q_cmd.addr_odd  = w0[0] ? w0[WORD_IDX_BITS-1:1] : w1[WORD_IDX_BITS-1:1];
    q_cmd.off       = off;
    q_cmd.len0      = len0;
    q_cmd.mask_lo   = m0;
    q_cmd.mask_hi   = m1;
    q_cmd.wmask_lo  = m0 << off;
    q_cmd.data_lo   = (in_mark_pattern & m0) << off;
    q_cmd.data_hi   = (in_mark_pattern >> len0) & m1;
  end

endmodule

// ===== hw/rtl/bts_queue.sv =====
// Two-entry command queue between the front end and the back end.
module bts_queue import bts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  bts_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output bts_cmd_t head
);

  bts_cmd_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;

  assign full      = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/bts_back.sv =====
// Back end: even and odd shadow word banks, read-modify-write and result register.
module bts_back import bts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  bts_cmd_t          q_head,
  output logic              q_pop,
  output logic              clear_done,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MARK_W-1:0] out_marks_found
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ} state_t;

  state_t                   state_r, state_nxt;
  logic [BANK_IDX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  bts_cmd_t                 cur_r, cur_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MARK_W-1:0]        out_marks_r, out_marks_nxt;

  logic [MARK_W-1:0]        mem_even_r [1 << BANK_IDX_BITS];
  logic [MARK_W-1:0]        mem_odd_r  [1 << BANK_IDX_BITS];
  logic [MARK_W-1:0]        rdata_even_r;
  logic [MARK_W-1:0]        rdata_odd_r;

  logic                     re;
  logic                     we;
  logic [BANK_IDX_BITS-1:0] waddr_even;
  logic [BANK_IDX_BITS-1:0] waddr_odd;
  logic [MARK_W-1:0]        wdata_even;
  logic [MARK_W-1:0]        wdata_odd;
  logic [MARK_W-1:0]        lo_word;
  logic [MARK_W-1:0]        hi_word;
  logic [MARK_W-1:0]        new_lo;
  logic [MARK_W-1:0]        new_hi;
  logic [MARK_W-1:0]        found;

  assign clear_done      = (state_r != ST_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_marks_found = out_marks_r;

  always_comb begin
    lo_word = cur_r.swap ? rdata_odd_r : rdata_even_r;
    hi_word = cur_r.swap ? rdata_even_r : rdata_odd_r;
    new_lo  = (lo_word & ~cur_r.wmask_lo) | cur_r.data_lo;
    new_hi  = (hi_word & ~cur_r.mask_hi) | cur_r.data_hi;
    found   = ((lo_word >> cur_r.off) & cur_r.mask_lo)
            | ((hi_word & cur_r.mask_hi) << cur_r.len0);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_marks_nxt = out_marks_r;
    q_pop         = 1'b0;
    re            = 1'b0;
    we            = 1'b0;
    waddr_even    = cur_r.addr_even;
    waddr_odd     = cur_r.addr_odd;
    wdata_even    = cur_r.swap ? new_hi : new_lo;
    wdata_odd     = cur_r.swap ? new_lo : new_hi;
    unique case (state_r)
      ST_CLEAR: begin
        we          = 1'b1;
        waddr_even  = clr_cnt_r;
        waddr_odd   = clr_cnt_r;
        wdata_even  = '0;
        wdata_odd   = '0;
        clr_cnt_nxt = clr_cnt_r + BANK_IDX_BITS'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          re        = 1'b1;
          cur_nxt   = q_head;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (!out_valid_r || out_ready) begin
          we            = (cur_r.func == FUNC_SET);
          out_valid_nxt = 1'b1;
          out_marks_nxt = (cur_r.func == FUNC_CHECK) ? found : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      out_marks_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      out_marks_r <= out_marks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_even_r[waddr_even] <= wdata_even;
      mem_odd_r[waddr_odd]   <= wdata_odd;
    end
    if (re) begin
      rdata_even_r <= mem_even_r[q_head.addr_even];
      rdata_odd_r  <= mem_odd_r[q_head.addr_odd];
    end
  end

endmodule

// ===== hw/rtl/byte_taint_shadow_map.sv =====
// Top level of the byte taint shadow map: front end, command queue and back end.
//
// Keeps one mark bit for every byte of a 64 KiB space in 1024 words of 64 bits,
// split into an even and an odd bank so that the two words a range may touch
// are read and written in the same cycle.
// The input channel (in_valid/in_ready) takes a word with a function (set or
// check), a start address, a count of 0 to 64 bytes and a mark pattern. The
// output channel (out_valid/out_ready) returns one word per input word: the
// marks of the range for a check, zero for a set.
// Each word passes the back end in order: a bank read, then the result and the
// write back; the back end takes no new word until it is done with the last.
// An accepted word is first registered in the command queue; its bank read and its result are registered too.
// After reset the block clears all 512 rows of both banks, one row per cycle;
// in_ready stays low during that pass.
// When the receiver stalls, the result is held in the output register, the
// next word waits in the back end and up to two more wait in the command
// queue before in_ready falls.
module byte_taint_shadow_map import bts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [15:0]        in_byte_address,
  input  logic [COUNT_W-1:0] in_byte_count,
  input  logic [MARK_W-1:0]  in_mark_pattern,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MARK_W-1:0]  out_marks_found
);

  bts_cmd_t push_cmd;
  bts_cmd_t head;
  logic     push;
  logic     pop;
  logic     full;
  logic     not_empty;
  logic     clear_done;

  bts_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_byte_address (in_byte_address),
    .in_byte_count   (in_byte_count),
    .in_mark_pattern (in_mark_pattern),
    .q_full          (full),
    .clear_done      (clear_done),
    .q_push          (push),
    .q_cmd           (push_cmd)
  );

  bts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  bts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (not_empty),
    .q_head          (head),
    .q_pop           (pop),
    .clear_done      (clear_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_marks_found (out_marks_found)
  );

endmodule

// ===== verif/tb_byte_taint_shadow_map.sv =====
// Self-checking testbench for the byte taint shadow map, with a mark-tracking scoreboard.
module tb_byte_taint_shadow_map;
  import bts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TOTAL    = 1 << (ADDR_BITS - OFF_BITS);
  localparam int RANDOM_WORDS  = 500;
  localparam int BURST_WORDS   = 16;
  localparam int RX_LONG_HOLD  = 200;
  localparam int MAX_IDLE      = 13;

  class mark_scoreboard;
    bit [MARK_W-1:0] shadow [WORD_TOTAL];
    bit [MARK_W-1:0] marks_due [$];
    int errors;
    int sets;
    int checks;
    int straddles;
    int wraps;
    int hits;

    function bit [MARK_W-1:0] ones_below(int n);
      if (n >= MARK_W) begin
        return '1;
      end
      return ~({MARK_W{1'b1}} << n);
    endfunction

    function void note_word(logic f, logic [15:0] addr, logic [COUNT_W-1:0] count,
                            logic [MARK_W-1:0] pat);
      int n;
      int off;
      int len0;
      int len1;
      bit [WORD_IDX_BITS-1:0] w0;
      bit [WORD_IDX_BITS-1:0] w1;
      bit [MARK_W-1:0] m0;
      bit [MARK_W-1:0] m1;
      bit [MARK_W-1:0] res;
      n = (count > FULL_COUNT) ? MARK_W : int'(count);
      off = int'(addr[OFF_BITS-1:0]);
      w0 = addr[ADDR_BITS-1:OFF_BITS];
      w1 = w0 + 1'b1;
      len0 = MARK_W - off;
      if (len0 > n) begin
        len0 = n;
      end
      len1 = n - len0;
      m0 = ones_below(len0);
      m1 = ones_below(len1);
      res = '0;
      if (n != 0) begin
        if (f == FUNC_SET) begin
          shadow[w0] = (shadow[w0] & ~(m0 << off)) | ((pat & m0) << off);
          if (len1 != 0) begin
            shadow[w1] = (shadow[w1] & ~m1) | ((pat >> len0) & m1);
          end
        end else begin
          res = (shadow[w0] >> off) & m0;
          if (len1 != 0) begin
            res |= (shadow[w1] & m1) << len0;
          end
        end
      end
      if (len1 != 0) begin
        straddles++;
        if (w1 == '0) begin
          wraps++;
        end
      end
      if (f == FUNC_SET) begin
        sets++;
      end else begin
        checks++;
      end
      if (res != '0) begin
        hits++;
      end
      marks_due.push_back(res);
    endfunction

    function void check_word(logic [MARK_W-1:0] actual);
      bit [MARK_W-1:0] wanted;
      if (marks_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual %h", $time, actual);
        return;
      end
      wanted = marks_due.pop_front();
      if (actual !== wanted) begin
        errors++;
        $display("%0t: marks_found mismatch: expected %h, actual %h", $time, wanted, actual);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_func = FUNC_SET;
  logic [15:0]        in_byte_address = '0;
  logic [COUNT_W-1:0] in_byte_count = '0;
  logic [MARK_W-1:0]  in_mark_pattern = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [MARK_W-1:0]  out_marks_found;

  mark_scoreboard sb = new;
  int  tx_max_gap = MAX_IDLE;
  int  rx_max_stall = MAX_IDLE;
  bit  rx_hold_req = 1'b0;

  byte_taint_shadow_map dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_byte_address (in_byte_address),
    .in_byte_count   (in_byte_count),
    .in_mark_pattern (in_mark_pattern),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_marks_found (out_marks_found)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_word(in_func, in_byte_address, in_byte_count, in_mark_pattern);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(out_marks_found);
    end
  end

  task automatic send_word(logic f, logic [15:0] addr, logic [COUNT_W-1:0] count,
                           logic [MARK_W-1:0] pat);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_byte_address <= addr;
    in_byte_count   <= count;
    in_mark_pattern <= pat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic               f;
    logic [15:0]        addr;
    logic [COUNT_W-1:0] count;
    logic [MARK_W-1:0]  pat;
    f = $urandom_range(0, 1) ? FUNC_CHECK : FUNC_SET;
    case ($urandom_range(0, 3))
      0, 1: addr = 16'($urandom_range(0, 511));
      2: addr = 16'hFF80 | 16'($urandom_range(0, 127));
      default: addr = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: count = '0;
      1: count = FULL_COUNT;
      2: count = COUNT_W'($urandom_range(65, 127));
      default: count = COUNT_W'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 7))
      0: pat = '0;
      1: pat = '1;
      default: pat = {$urandom, $urandom};
    endcase
    send_word(f, addr, count, pat);
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (sb.marks_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = $urandom_range(0, rx_max_stall);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int phase;
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_word(FUNC_CHECK, 16'h0000, FULL_COUNT, '1);
    send_word(FUNC_SET,   16'h0000, FULL_COUNT, '1);
    send_word(FUNC_CHECK, 16'h0000, FULL_COUNT, '0);
    send_word(FUNC_SET,   16'hFFE0, FULL_COUNT, 64'hA5A5_0F0F_3C3C_9696);
    send_word(FUNC_CHECK, 16'hFFE0, FULL_COUNT, '0);
    send_word(FUNC_CHECK, 16'h0000, FULL_COUNT, '0);
    send_word(FUNC_CHECK, 16'hFFC0, FULL_COUNT, '0);
    send_word(FUNC_SET,   16'h0005, 7'd0, '1);
    send_word(FUNC_CHECK, 16'h0005, 7'd0, '0);
    send_word(FUNC_SET,   16'h0064, 7'd127, 64'h1234_5678_9ABC_DEF0);
    send_word(FUNC_CHECK, 16'h0064, 7'd100, '0);
    send_word(FUNC_CHECK, 16'h0064, FULL_COUNT, '0);
    send_word(FUNC_SET,   16'h0123, 7'd50, 64'hFFFF_0000_FFFF_0000);
    send_word(FUNC_CHECK, 16'h0100, FULL_COUNT, '0);
    send_word(FUNC_CHECK, 16'h0140, FULL_COUNT, '0);
    send_word(FUNC_SET,   16'h01BF, 7'd2, 64'h2);
    send_word(FUNC_CHECK, 16'h01BE, 7'd4, '0);
    send_word(FUNC_SET,   16'h00C8, 7'd5, '1);
    send_word(FUNC_CHECK, 16'h00C4, 7'd16, '0);
    send_word(FUNC_SET,   16'hFFFF, 7'd1, '1);
    send_word(FUNC_CHECK, 16'hFFFF, FULL_COUNT, '0);
    send_word(FUNC_SET,   16'hFFFF, FULL_COUNT, '0);
    send_word(FUNC_CHECK, 16'hFFFF, FULL_COUNT, '1);
    send_word(FUNC_CHECK, 16'h0000, 7'd1, '0);

    for (phase = 0; phase < 4; phase++) begin
      tx_max_gap   = (phase == 1 || phase == 2) ? 0 : MAX_IDLE;
      rx_max_stall = (phase == 1 || phase == 3) ? 0 : MAX_IDLE;
      for (k = 0; k < RANDOM_WORDS / 4; k++) begin
        send_random_word();
      end
      if (phase == 0) begin
        in_valid <= 1'b0;
        drain_results();
      end
      if (phase == 1) begin
        rx_hold_req = 1'b1;
        for (k = 0; k < BURST_WORDS; k++) begin
          send_random_word();
        end
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (16) @(posedge clk);

    $display("Covered %0d sets and %0d checks, %0d ranges across two words (%0d wrapping).",
             sb.sets, sb.checks, sb.straddles, sb.wraps);
    $display("%0d checks returned marked bytes; %0d mismatches seen.", sb.hits, sb.errors);
    if (sb.errors == 0 && sb.marks_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
